// ----- design/skpe_pkg.sv -----
// Shared constants and helpers for the serial keyboard protocol engine.
package skpe_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int NOW_W   = 48;
    localparam int DELAY_W = 16;
    localparam int TMO_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 7;
    localparam int CFG_W   = 24;
    localparam int CFG_IW  = 2;

    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_SR   = 2'd1;
    localparam logic [1:0] OP_ACR  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [CFG_IW-1:0] CFG_BYTE_DELAY = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_INQ_TMO    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MODEL      = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_INQUIRY = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_INSTANT = 8'h14;
    localparam logic [BYTE_W-1:0] CMD_MODEL   = 8'h16;
    localparam logic [BYTE_W-1:0] CMD_TEST    = 8'h36;

    localparam logic [BYTE_W-1:0] NULL_REPLY   = 8'h7B;
    localparam logic [BYTE_W-1:0] TEST_REPLY   = 8'h7D;
    localparam logic [BYTE_W-1:0] EXT_PREFIX   = 8'd121;
    localparam logic [BYTE_W-1:0] OTHER_REPLY  = 8'h00;
    localparam logic [2:0]        SR_MODE_OUT  = 3'd6;

    localparam logic [DELAY_W-1:0] BYTE_DELAY_RST = 16'd8000;
    localparam logic [TMO_W-1:0]   INQ_TMO_RST    = 24'd2000000;
    localparam logic [BYTE_W-1:0]  MODEL_RST      = 8'h0B;

    function automatic logic [QUEUE_AW-1:0] ring_inc(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] r;
        if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- design/serial_keyboard_protocol_engine.sv -----
// Top level of the serial keyboard protocol engine: key queue, command link and result stage.
// The engine takes one word per cycle on the input channel and returns one result word for
// each, which passes first through the input register and then through the result
// register. All step logic sits between those two registers, so the throughput is one word
// per clock whenever the result side keeps taking words. Key events are held in a ring RAM
// of QUEUE_DEPTH entries with a registered read port that always reads the current head;
// a one-entry bypass covers a key written to the head slot in the same cycle. Configuration
// writes take effect on the next clock edge and are meant to be issued while the engine is
// idle.
module serial_keyboard_protocol_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [skpe_pkg::NOW_W-1:0]    s_now,
    input  logic [skpe_pkg::CODE_W-1:0]   s_key_code,
    input  logic                          s_key_down,
    input  logic [skpe_pkg::BYTE_W-1:0]   s_reg_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [skpe_pkg::BYTE_W-1:0]   m_shift_value,
    output logic                          m_reply_loaded,
    output logic                          m_irq_raise,
    output logic                          m_irq_sr_clear,
    output logic                          m_data_line,
    output logic                          m_key_dropped,
    input  logic                          cfg_we,
    input  logic [skpe_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [skpe_pkg::CFG_W-1:0]    cfg_data
);
    import skpe_pkg::*;

    typedef enum logic [1:0] {
        LS_IDLE    = 2'd0,
        LS_RX_CMD  = 2'd1,
        LS_GOT_CMD = 2'd2,
        LS_RX_END  = 2'd3
    } link_state_t;

    typedef enum logic [1:0] {
        TK_NONE = 2'd0,
        TK_CMD  = 2'd1,
        TK_END  = 2'd2
    } timed_kind_t;

    // Configuration.
    logic [DELAY_W-1:0] byte_delay_reg;
    logic [TMO_W-1:0]   inq_tmo_reg;
    logic [BYTE_W-1:0]  model_reg;

    // Input register.
    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic [NOW_W-1:0]   in_now_reg;
    logic [CODE_W-1:0]  in_code_reg;
    logic               in_down_reg;
    logic [BYTE_W-1:0]  in_val_reg;

    // Engine state.
    link_state_t        link_reg, link_next;
    logic               held_reg, held_next;
    logic [BYTE_W-1:0]  reply_reg, reply_next;
    logic [BYTE_W-1:0]  instant_reg, instant_next;
    logic               wait_reg, wait_next;
    logic [NOW_W-1:0]   inq_due_reg, inq_due_next;
    timed_kind_t        kind_reg, kind_next;
    logic [NOW_W-1:0]   timed_due_reg, timed_due_next;
    logic [QUEUE_AW-1:0] head_reg, head_next;
    logic [QUEUE_AW-1:0] tail_reg, tail_next;
    logic [BYTE_W-1:0]  shift_reg, shift_next;
    logic               line_reg, line_next;
    logic [BYTE_W-1:0]  acr_reg, acr_next;

    // Head bypass.
    logic               byp_valid_reg;
    logic [BYTE_W-1:0]  byp_data_reg;

    // Result register.
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  m_shift_reg;
    logic               m_loaded_reg, m_irq_reg, m_clear_reg, m_line_reg, m_drop_reg;

    // Step signals.
    logic               proc;
    logic               loaded, irq, sr_clear, dropped;
    logic               ring_we;
    logic [BYTE_W-1:0]  ring_wdata;
    logic [BYTE_W-1:0]  ram_q;
    logic [BYTE_W-1:0]  head_word;
    logic               ring_empty;
    logic [QUEUE_AW-1:0] tail_inc;
    logic [QUEUE_AW-1:0] ram_raddr;
    logic               pop_ext;
    logic [BYTE_W-1:0]  pop_shifted;
    logic [BYTE_W-1:0]  pop_data;
    logic [NOW_W-1:0]   now_plus_delay;
    logic [NOW_W-1:0]   now_plus_tmo;

    assign proc    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    assign tail_inc       = ring_inc(tail_reg);
    assign ring_empty     = (head_reg == tail_reg);
    assign head_word      = byp_valid_reg ? byp_data_reg : ram_q;
    assign pop_ext        = head_word[CODE_W-1];
    assign pop_shifted    = {head_word[BYTE_W-1], head_word[CODE_W-2:0], 1'b0};
    assign pop_data       = pop_ext ? EXT_PREFIX : pop_shifted;
    assign ring_wdata     = {!in_down_reg, in_code_reg};
    assign now_plus_delay = in_now_reg + NOW_W'(byte_delay_reg);
    assign now_plus_tmo   = in_now_reg + NOW_W'(inq_tmo_reg);

    always_comb begin
        link_next      = link_reg;
        held_next      = held_reg;
        reply_next     = reply_reg;
        instant_next   = instant_reg;
        wait_next      = wait_reg;
        inq_due_next   = inq_due_reg;
        kind_next      = kind_reg;
        timed_due_next = timed_due_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        shift_next     = shift_reg;
        line_next      = line_reg;
        acr_next       = acr_reg;
        loaded         = 1'b0;
        irq            = 1'b0;
        sr_clear       = 1'b0;
        dropped        = 1'b0;
        ring_we        = 1'b0;

        case (in_op_reg)
            OP_KEY: begin
                if (tail_inc == head_reg) begin
                    dropped = 1'b1;
                end else begin
                    ring_we   = 1'b1;
                    tail_next = tail_inc;
                end
            end
            OP_SR: begin
                shift_next = in_val_reg;
                sr_clear   = 1'b1;
                if (acr_reg[4:2] == SR_MODE_OUT && in_val_reg == '0 && line_reg) begin
                    line_next = 1'b0;
                    if (link_reg == LS_IDLE) begin
                        link_next      = LS_RX_CMD;
                        kind_next      = TK_CMD;
                        timed_due_next = now_plus_delay;
                        wait_next      = 1'b0;
                    end
                end
            end
            OP_ACR: begin
                acr_next = in_val_reg;
                if ((acr_reg[4] ^ in_val_reg[4]) && !in_val_reg[4] && !line_reg) begin
                    line_next = 1'b1;
                    if (link_reg == LS_GOT_CMD) begin
                        link_next      = LS_RX_END;
                        kind_next      = TK_END;
                        timed_due_next = now_plus_delay;
                    end
                end
            end
            default: begin
                if (kind_reg != TK_NONE && in_now_reg >= timed_due_reg) begin
                    kind_next = TK_NONE;
                    if (kind_reg == TK_CMD) begin
                        // The link is busy from here on, so the reply is held, unless an inquiry finds the queue empty.
                        irq       = 1'b1;
                        line_next = shift_reg[0];
                        link_next = LS_GOT_CMD;
                        held_next = 1'b1;
                        case (shift_reg)
                            CMD_INQUIRY: begin
                                if (!ring_empty) begin
                                    head_next  = ring_inc(head_reg);
                                    reply_next = pop_data;
                                    if (pop_ext) begin
                                        instant_next = pop_shifted;
                                    end
                                end else begin
                                    held_next    = held_reg;
                                    wait_next    = 1'b1;
                                    inq_due_next = now_plus_tmo;
                                end
                            end
                            CMD_INSTANT: begin
                                reply_next   = instant_reg;
                                instant_next = NULL_REPLY;
                            end
                            CMD_MODEL: reply_next = model_reg;
                            CMD_TEST:  reply_next = TEST_REPLY;
                            default:   reply_next = OTHER_REPLY;
                        endcase
                    end else begin
                        link_next = LS_IDLE;
                        if (held_reg) begin
                            held_next  = 1'b0;
                            shift_next = reply_reg;
                            irq        = 1'b1;
                            loaded     = 1'b1;
                            line_next  = 1'b1;
                        end
                    end
                end
                // A waiting inquiry never coincides with a pop by the command above.
                if (wait_next && (!ring_empty || in_now_reg >= inq_due_next)) begin
                    wait_next = 1'b0;
                    if (link_next != LS_IDLE) begin
                        held_next  = 1'b1;
                        reply_next = ring_empty ? NULL_REPLY : pop_data;
                    end else begin
                        shift_next = ring_empty ? NULL_REPLY : pop_data;
                        irq        = 1'b1;
                        loaded     = 1'b1;
                        line_next  = 1'b1;
                    end
                    if (!ring_empty) begin
                        head_next = ring_inc(head_reg);
                        if (pop_ext) begin
                            instant_next = pop_shifted;
                        end
                    end
                end
            end
        endcase
    end

    assign ram_raddr = proc ? head_next : head_reg;

    skpe_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (proc && ring_we),
        .waddr (tail_reg),
        .wdata (ring_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_delay_reg <= BYTE_DELAY_RST;
            inq_tmo_reg    <= INQ_TMO_RST;
            model_reg      <= MODEL_RST;
            in_valid_reg   <= 1'b0;
            link_reg       <= LS_IDLE;
            held_reg       <= 1'b0;
            reply_reg      <= '0;
            instant_reg    <= NULL_REPLY;
            wait_reg       <= 1'b0;
            inq_due_reg    <= '0;
            kind_reg       <= TK_NONE;
            timed_due_reg  <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            shift_reg      <= '0;
            line_reg       <= 1'b1;
            acr_reg        <= '0;
            byp_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_BYTE_DELAY: byte_delay_reg <= cfg_data[DELAY_W-1:0];
                    CFG_INQ_TMO:    inq_tmo_reg    <= cfg_data[TMO_W-1:0];
                    CFG_MODEL:      model_reg      <= cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end

            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            if (s_valid && s_ready) begin
                in_op_reg   <= s_op;
                in_now_reg  <= s_now;
                in_code_reg <= s_key_code;
                in_down_reg <= s_key_down;
                in_val_reg  <= s_reg_value;
            end

            byp_valid_reg <= proc && ring_we && (tail_reg == ram_raddr);
            byp_data_reg  <= ring_wdata;

            if (proc) begin
                link_reg      <= link_next;
                held_reg      <= held_next;
                reply_reg     <= reply_next;
                instant_reg   <= instant_next;
                wait_reg      <= wait_next;
                inq_due_reg   <= inq_due_next;
                kind_reg      <= kind_next;
                timed_due_reg <= timed_due_next;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                shift_reg     <= shift_next;
                line_reg      <= line_next;
                acr_reg       <= acr_next;
                m_valid_reg   <= 1'b1;
                m_shift_reg   <= shift_next;
                m_loaded_reg  <= loaded;
                m_irq_reg     <= irq;
                m_clear_reg   <= sr_clear;
                m_line_reg    <= line_next;
                m_drop_reg    <= dropped;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_shift_value  = m_shift_reg;
    assign m_reply_loaded = m_loaded_reg;
    assign m_irq_raise    = m_irq_reg;
    assign m_irq_sr_clear = m_clear_reg;
    assign m_data_line    = m_line_reg;
    assign m_key_dropped  = m_drop_reg;

endmodule

// ----- design/skpe_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module skpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
